### src/bmdf_pkg.sv
// ----------------------------------------------------------------------------
// bmdf_pkg: shared types and constants
// Sample width, register indexes, level codes and the cell interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package bmdf_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned LevelW  = 2;
  localparam int unsigned CfgIdxW = 2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegFloor = 2'd0;
  localparam logic [CfgIdxW-1:0] RegNear  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegFar   = 2'd2;

  // Register reset values
  localparam logic [SampleW-1:0] FloorRst = 16'd10;
  localparam logic [SampleW-1:0] NearRst  = 16'd40;
  localparam logic [SampleW-1:0] FarRst   = 16'd100;

  // Level codes
  localparam logic [LevelW-1:0] LevelFar  = 2'd0;
  localparam logic [LevelW-1:0] LevelMid  = 2'd1;
  localparam logic [LevelW-1:0] LevelNear = 2'd2;

  // One slot of the sorted chain
  typedef struct packed {
    logic               vld;
    logic [SampleW-1:0] val;
  } slot_t;

  // Per-cell control from the top level
  typedef struct packed {
    logic load;   // a sample is transferred this cycle
    logic flush;  // batch complete: restart with the new sample
    logic head;   // this is the first cell of the chain
  } cell_ctl_t;

endpackage

`default_nettype wire

### src/bmdf_cell.sv
// ----------------------------------------------------------------------------
// bmdf_cell: one slot of the sorted insertion chain
// Holds one sample; on insert it keeps, takes the new sample or takes its
// left neighbor's value, which keeps the chain in ascending order; a flush leaves only the head filled.
// ----------------------------------------------------------------------------
`default_nettype none

module bmdf_cell (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire bmdf_pkg::cell_ctl_t    ctl_i,
  input  wire [bmdf_pkg::SampleW-1:0] sample_i,
  input  wire bmdf_pkg::slot_t        left_i,
  input  wire                         left_shift_i,
  output bmdf_pkg::slot_t             slot_o,
  output logic                        shift_o
);

  logic                         vld_q, vld_d;
  logic [bmdf_pkg::SampleW-1:0] val_q, val_d;

  // Empty slot or larger value: this slot moves right on insert
  assign shift_o = !vld_q || (val_q > sample_i);

  always_comb begin
    vld_d = vld_q;
    val_d = val_q;
    if (ctl_i.load) begin
      if (ctl_i.flush) begin
        vld_d = ctl_i.head;
        val_d = sample_i;
      end else if (shift_o) begin
        if (!left_shift_i) begin
          vld_d = 1'b1;
          val_d = sample_i;
        end else begin
          vld_d = left_i.vld;
          val_d = left_i.val;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign slot_o.vld = vld_q;
  assign slot_o.val = val_q;

endmodule

`default_nettype wire

### src/batch_median_distance_filter.sv
// ----------------------------------------------------------------------------
// batch_median_distance_filter: batch median of distance samples
// Keeps each batch sorted in a chain of cells and classes its median against
// floor, near and far thresholds.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------
//  in      | input     | in_valid_i / in_ready_o | sample_i
//  out     | output    | out_valid_o/out_ready_i | median_o, level_o, report_o
//  cfg     | input     | cfg_we_i (no wait)      | cfg_idx_i, cfg_data_i
//
//  One sample per cycle while in_ready_o is high; each insert is registered in the cell chain.
//  A result shows in the cycle after a transfer that lands on a full batch.
//  Reset empties the chain and loads the default thresholds.
//  in_ready_o drops only while a result waits and out_ready_i is low.
// ----------------------------------------------------------------------------
`default_nettype none

module batch_median_distance_filter #(
  parameter int unsigned WINDOW = 15
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // sample channel
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire  [bmdf_pkg::SampleW-1:0] sample_i,
  // result channel
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic [bmdf_pkg::SampleW-1:0] median_o,
  output logic [bmdf_pkg::LevelW-1:0]  level_o,
  output logic                         report_o,
  // configuration
  input  wire                          cfg_we_i,
  input  wire  [bmdf_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire  [bmdf_pkg::SampleW-1:0] cfg_data_i
);

  localparam int unsigned Mid = WINDOW / 2;

  // --------------------------------------------------------------------------
  // Threshold registers
  // --------------------------------------------------------------------------
  logic [bmdf_pkg::SampleW-1:0] floor_q, floor_d;
  logic [bmdf_pkg::SampleW-1:0] near_q, near_d;
  logic [bmdf_pkg::SampleW-1:0] far_q, far_d;

  always_comb begin
    floor_d = floor_q;
    near_d  = near_q;
    far_d   = far_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bmdf_pkg::RegFloor: floor_d = cfg_data_i;
        bmdf_pkg::RegNear:  near_d  = cfg_data_i;
        bmdf_pkg::RegFar:   far_d   = cfg_data_i;
        default: ;  // writes past the last register are dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q <= bmdf_pkg::FloorRst;
      near_q  <= bmdf_pkg::NearRst;
      far_q   <= bmdf_pkg::FarRst;
    end else begin
      floor_q <= floor_d;
      near_q  <= near_d;
      far_q   <= far_d;
    end
  end

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  logic in_xfer;
  logic full;
  logic out_valid_q, out_valid_d;

  // Output register decouples the two sides: accept whenever it can drain
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  // --------------------------------------------------------------------------
  // Sorted cell chain
  // --------------------------------------------------------------------------
  bmdf_pkg::slot_t     slot  [WINDOW];
  logic [WINDOW-1:0]   shift;
  logic [WINDOW-1:0]   vld_vec;

  // Last slot filled means the batch holds WINDOW samples
  assign full = slot[WINDOW-1].vld;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    bmdf_pkg::cell_ctl_t ctl;
    bmdf_pkg::slot_t     left;
    logic                left_shift;

    assign ctl.load  = in_xfer;
    assign ctl.flush = full;
    assign ctl.head  = (i == 0);

    if (i == 0) begin : g_head
      assign left.vld   = 1'b0;
      assign left.val   = '0;
      assign left_shift = 1'b0;
    end else begin : g_body
      assign left       = slot[i-1];
      assign left_shift = shift[i-1];
    end

    bmdf_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .sample_i     (sample_i),
      .left_i       (left),
      .left_shift_i (left_shift),
      .slot_o       (slot[i]),
      .shift_o      (shift[i])
    );

    assign vld_vec[i] = slot[i].vld;
  end

  // --------------------------------------------------------------------------
  // Median classing and output register
  // --------------------------------------------------------------------------
  logic [bmdf_pkg::SampleW-1:0] med;
  logic                         rep;
  logic [bmdf_pkg::LevelW-1:0]  lvl;
  logic [bmdf_pkg::SampleW-1:0] median_q;
  logic [bmdf_pkg::LevelW-1:0]  level_q;
  logic                         report_q;

  assign med = slot[Mid].val;
  assign rep = med > floor_q;

  // Near test has priority, thresholds applied as programmed
  always_comb begin
    if (rep && (med < near_q)) begin
      lvl = bmdf_pkg::LevelNear;
    end else if (rep && (med < far_q)) begin
      lvl = bmdf_pkg::LevelMid;
    end else begin
      lvl = bmdf_pkg::LevelFar;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_xfer && full) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && full) begin
      median_q <= med;
      level_q  <= lvl;
      report_q <= rep;
    end
  end

  assign out_valid_o = out_valid_q;
  assign median_o    = median_q;
  assign level_o     = level_q;
  assign report_o    = report_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef NO_ASSERTIONS
  // Filled slots are always packed at the low end of the chain
  a_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((vld_vec + {{(WINDOW-1){1'b0}}, 1'b1}) & vld_vec) == '0)
    else $error("cell chain has a gap");

  // Completing a batch leaves exactly the new sample in the chain
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && full) |=> ($countones(vld_vec) == 1))
    else $error("chain not restarted after batch");

  // Completing a batch always raises a result
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && full) |=> out_valid_o)
    else $error("result missing after batch");

  // A non-completing insert adds exactly one filled slot
  a_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && !full) |=> ($countones(vld_vec) == $countones($past(vld_vec)) + 1))
    else $error("insert did not grow the batch");
`endif

endmodule

`default_nettype wire

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for batch_median_distance_filter
// Streams distance samples through the valid/ready channels with bursty
// sending and patterned back-pressure. A local batch/sort model predicts each
// median with its level and report flag, and every result transfer is checked
// in order. Threshold registers are reloaded between phases, extremes and
// out-of-order settings included.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BatchLen   = 15;
  localparam int unsigned ItemTarget = 750;
  // Worst case is roughly 870 samples with the longest sender gap each, plus about
  // 58 results that may sit through a starved receiver, plus drain pauses.
  // Several times that still stays far below this bound.
  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned SettleCyc  = 4;   // result shows in the cycle after its transfer

  // Index past the register list: the block must ignore writes to it
  localparam logic [bmdf_pkg::CfgIdxW-1:0] RegUnused = 2'd3;

  typedef enum logic [1:0] {RxFree, RxCoin, RxStarve, RxBeat} rx_mode_e;

  typedef struct packed {
    logic [bmdf_pkg::SampleW-1:0] median;
    logic [bmdf_pkg::LevelW-1:0]  level;
    logic                         report;
  } median_exp_t;

  // DUT-facing signals; the inputs driven here are all known from time zero
  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         in_valid_i  = 1'b0;
  logic                         in_ready_o;
  logic [bmdf_pkg::SampleW-1:0] sample_i    = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic [bmdf_pkg::SampleW-1:0] median_o;
  logic [bmdf_pkg::LevelW-1:0]  level_o;
  logic                         report_o;
  logic                         cfg_we_i    = 1'b0;
  logic [bmdf_pkg::CfgIdxW-1:0] cfg_idx_i   = '0;
  logic [bmdf_pkg::SampleW-1:0] cfg_data_i  = '0;

  batch_median_distance_filter #(
    .WINDOW(BatchLen)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sample_i   (sample_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .median_o   (median_o),
    .level_o    (level_o),
    .report_o   (report_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // Model state: thresholds, the batch being filled, pending medians
  // --------------------------------------------------------------------------
  logic [bmdf_pkg::SampleW-1:0] floor_lim = bmdf_pkg::FloorRst;
  logic [bmdf_pkg::SampleW-1:0] near_lim  = bmdf_pkg::NearRst;
  logic [bmdf_pkg::SampleW-1:0] far_lim   = bmdf_pkg::FarRst;
  logic [bmdf_pkg::SampleW-1:0] batch_mem [BatchLen];
  int unsigned                  batch_fill = 0;
  median_exp_t                  median_exp_q [$];

  // Run statistics
  int unsigned mismatch_cnt    = 0;
  int unsigned samples_sent    = 0;
  int unsigned medians_checked = 0;
  int unsigned cfg_writes      = 0;
  int unsigned level_tally [3] = '{0, 0, 0};
  int unsigned unreported_cnt  = 0;

  // Sender burst bookkeeping
  int unsigned burst_left = 0;

  // --------------------------------------------------------------------------
  // Clock, reset, watchdog
  // --------------------------------------------------------------------------
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  int unsigned cycle_cnt = 0;
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("%0t: run stalled, %0d medians still pending", $time, median_exp_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Median model. A sample that lands on a full batch closes it: sort,
  // take the middle entry, class it, then the sample opens the next batch.
  // --------------------------------------------------------------------------
  task automatic predict_median(input logic [bmdf_pkg::SampleW-1:0] dist_cm);
    logic [bmdf_pkg::SampleW-1:0] sorted [BatchLen];
    logic [bmdf_pkg::SampleW-1:0] key;
    median_exp_t                  exp_r;
    int                           j;
    if (batch_fill >= BatchLen) begin
      sorted = batch_mem;
      for (int i = 1; i < BatchLen; i++) begin
        key = sorted[i];
        j   = i;
        while (j > 0 && sorted[j-1] > key) begin
          sorted[j] = sorted[j-1];
          j--;
        end
        sorted[j] = key;
      end
      exp_r.median = sorted[BatchLen/2];
      exp_r.report = (exp_r.median > floor_lim);
      // near test before far test, even if the limits are out of order
      if (exp_r.report && exp_r.median < near_lim) begin
        exp_r.level = bmdf_pkg::LevelNear;
      end else if (exp_r.report && exp_r.median < far_lim) begin
        exp_r.level = bmdf_pkg::LevelMid;
      end else begin
        exp_r.level = bmdf_pkg::LevelFar;
      end
      median_exp_q.push_back(exp_r);
      level_tally[exp_r.level]++;
      if (!exp_r.report) unreported_cnt++;
      foreach (batch_mem[i]) batch_mem[i] = '0;
      batch_mem[0] = dist_cm;
      batch_fill   = 1;
    end else begin
      batch_mem[batch_fill] = dist_cm;
      batch_fill++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Result checker: every result transfer pops the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    median_exp_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (median_exp_q.size() == 0) begin
        $display("%0t: unexpected result median %0d level %0d report %0d",
                 $time, median_o, level_o, report_o);
        mismatch_cnt++;
      end else begin
        exp_r = median_exp_q.pop_front();
        medians_checked++;
        if (median_o !== exp_r.median) begin
          $display("%0t: median expected %0d actual %0d", $time, exp_r.median, median_o);
          mismatch_cnt++;
        end
        if (level_o !== exp_r.level) begin
          $display("%0t: level expected %0d actual %0d (median %0d)",
                   $time, exp_r.level, level_o, exp_r.median);
          mismatch_cnt++;
        end
        if (report_o !== exp_r.report) begin
          $display("%0t: report expected %0d actual %0d (median %0d)",
                   $time, exp_r.report, report_o, exp_r.median);
          mismatch_cnt++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver back-pressure: a mode is held for a random stretch, then redrawn.
  // RxFree gives long runs with no stall at all.
  // --------------------------------------------------------------------------
  rx_mode_e    rx_mode = RxFree;
  int unsigned rx_left = 0;
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 160);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RxFree:   out_ready_i <= 1'b1;
      RxCoin:   out_ready_i <= 1'($urandom_range(0, 1));
      RxStarve: out_ready_i <= ($urandom_range(0, 7) == 0);
      default:  out_ready_i <= rx_left[2];
    endcase
  end

  // --------------------------------------------------------------------------
  // Sender. valid stays high across back-to-back samples; whatever follows
  // a send must lower it at the next falling edge (see stop_sending).
  // --------------------------------------------------------------------------
  task automatic send_sample(input logic [bmdf_pkg::SampleW-1:0] dist_cm);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end
    burst_left--;
    if (gap > 0) begin
      @(negedge clk_i) in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    sample_i   <= dist_cm;
    do @(posedge clk_i); while (!in_ready_o);
    predict_median(dist_cm);
    samples_sent++;
  endtask

  task automatic stop_sending();
    @(negedge clk_i) in_valid_i <= 1'b0;
  endtask

  // Pause the sender until every pending median has been transferred,
  // then let the chain settle (a trailing sample may still be inserting).
  task automatic wait_idle();
    stop_sending();
    while (median_exp_q.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  // Reload all thresholds on an idle block, plus one write past the list
  task automatic load_thresholds(input logic [bmdf_pkg::SampleW-1:0] floor_v,
                                 input logic [bmdf_pkg::SampleW-1:0] near_v,
                                 input logic [bmdf_pkg::SampleW-1:0] far_v);
    logic [bmdf_pkg::CfgIdxW-1:0] idx_seq  [4];
    logic [bmdf_pkg::SampleW-1:0] data_seq [4];
    wait_idle();
    idx_seq  = '{bmdf_pkg::RegFar, RegUnused, bmdf_pkg::RegFloor, bmdf_pkg::RegNear};
    data_seq = '{far_v, 16'($urandom), floor_v, near_v};
    for (int i = 0; i < 4; i++) begin
      @(negedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx_seq[i];
      cfg_data_i <= data_seq[i];
      @(posedge clk_i);
      case (idx_seq[i])
        bmdf_pkg::RegFloor: floor_lim = data_seq[i];
        bmdf_pkg::RegNear:  near_lim  = data_seq[i];
        bmdf_pkg::RegFar:   far_lim   = data_seq[i];
        default:  ;  // out of range: dropped
      endcase
      cfg_writes++;
    end
    @(negedge clk_i) cfg_we_i <= 1'b0;
  endtask

  // Sample mix. Values clustered on the current limits (one below, on,
  // one above) make medians land exactly on the comparison edges.
  function automatic logic [bmdf_pkg::SampleW-1:0] next_sample(input bit edge_heavy);
    int unsigned                  pick;
    logic [bmdf_pkg::SampleW-1:0] base;
    pick = edge_heavy ? ($urandom_range(0, 4) == 0 ? 9 : 4) : $urandom_range(0, 9);
    case ($urandom_range(0, 2))
      0:       base = floor_lim;
      1:       base = near_lim;
      default: base = far_lim;
    endcase
    if (pick <= 2) return 16'($urandom);
    if (pick <= 6) return base + 16'($urandom_range(0, 2)) - 16'd1;
    if (pick <= 8) return 16'($urandom_range(0, 150));
    return ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
  endfunction

  task automatic send_batches(input int unsigned n_batches, input bit edge_heavy);
    repeat (n_batches * BatchLen) send_sample(next_sample(edge_heavy));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Default thresholds straight out of reset. Nothing may come out for the
  // first 15 samples; the 16th closes the batch. Batch holds 0, full scale
  // and a walking one up to bit 12, so the median is 64 (mid range).
  task automatic test_first_batch();
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    for (int i = 0; i < 13; i++) send_sample(16'(1 << i));
    send_sample(16'hAAAA);
  endtask

  // Corner threshold settings: all zero, all full scale, near above far,
  // floor above both, wide open, and back to the reset values.
  task automatic test_threshold_corners();
    load_thresholds(16'd0, 16'd0, 16'd0);
    send_batches(2, 1'b1);
    load_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_batches(2, 1'b1);
    load_thresholds(16'd20, 16'd100, 16'd40);
    send_batches(2, 1'b1);
    load_thresholds(16'd500, 16'd100, 16'd300);
    send_batches(2, 1'b1);
    load_thresholds(16'd0, 16'hFFFF, 16'hFFFF);
    send_batches(2, 1'b1);
    load_thresholds(bmdf_pkg::FloorRst, bmdf_pkg::NearRst, bmdf_pkg::FarRst);
    send_batches(2, 1'b1);
  endtask

  // Long random stream in phases of random length. Most phases start with
  // a drained block and new limits: ordered small, full random, or shuffled.
  task automatic test_random_stream();
    logic [bmdf_pkg::SampleW-1:0] f_v, n_v, x_v;
    int unsigned                  phase_len;
    while (samples_sent < ItemTarget) begin
      case ($urandom_range(0, 3))
        0: begin
          f_v = 16'($urandom_range(0, 60));
          n_v = f_v + 16'($urandom_range(0, 80));
          x_v = n_v + 16'($urandom_range(0, 120));
          load_thresholds(f_v, n_v, x_v);
        end
        1: load_thresholds(16'($urandom), 16'($urandom), 16'($urandom));
        2: load_thresholds(16'($urandom_range(0, 200)), 16'($urandom_range(0, 200)),
                           16'($urandom_range(0, 200)));
        default: ;  // keep streaming across the phase boundary
      endcase
      phase_len = $urandom_range(20, 120);
      repeat (phase_len) send_sample(next_sample(1'b0));
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    test_first_batch();
    test_threshold_corners();
    test_random_stream();

    // all stimulus is in; wait out the last medians and the chain latency
    wait_idle();
    repeat (8) @(posedge clk_i);

    $display("Run covered %0d samples, %0d medians checked, %0d register writes.",
             samples_sent, medians_checked, cfg_writes);
    $display("Levels near/mid/far: %0d/%0d/%0d, medians at or below floor: %0d.",
             level_tally[bmdf_pkg::LevelNear], level_tally[bmdf_pkg::LevelMid],
             level_tally[bmdf_pkg::LevelFar], unreported_cnt);
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
